### src/tick_task_scheduler_with_clock_defines.svh
// Assertion macros shared by the scheduler RTL.
`ifndef TICK_TASK_SCHEDULER_WITH_CLOCK_DEFINES_SVH
`define TICK_TASK_SCHEDULER_WITH_CLOCK_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TTS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: ante |-> cons");

// Next-cycle implication, disabled while reset is asserted.
`define TTS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: ante |=> cons");

`endif

### src/tts_pkg.sv
`timescale 1ns / 1ps

package tts_pkg;

	localparam int DIV_W  = 16;
	localparam int CNT_W  = 32;
	localparam int SEC_W  = 6;
	localparam int MIN_W  = 6;
	localparam int HR_W   = 5;
	localparam int FLAG_W = 4;
	localparam int IDX_W  = 8;

	localparam logic [SEC_W:0] SEC_MOD = 7'd60;
	localparam logic [MIN_W:0] MIN_MOD = 7'd60;
	localparam logic [HR_W:0]  HR_MOD  = 6'd24;

	localparam logic [DIV_W-1:0] PERIOD_SHORT_RST = 16'd5;
	localparam logic [DIV_W-1:0] PERIOD_MID_RST   = 16'd50;
	localparam logic [DIV_W-1:0] PERIOD_LONG_RST  = 16'd500;
	localparam logic [DIV_W-1:0] TICKS_PER_SEC_RST = 16'd1000;

	localparam logic [IDX_W-1:0] REG_PERIOD_SHORT  = 8'd0;
	localparam logic [IDX_W-1:0] REG_PERIOD_MID    = 8'd1;
	localparam logic [IDX_W-1:0] REG_PERIOD_LONG   = 8'd2;
	localparam logic [IDX_W-1:0] REG_TICKS_PER_SEC = 8'd3;

	typedef struct packed {
		logic [SEC_W-1:0] sec;
		logic [MIN_W-1:0] min;
		logic [HR_W-1:0]  hr;
	} tod_t;

	typedef struct packed {
		logic              tick;
		logic              task_ran;
		logic [FLAG_W-1:0] ack_mask;
		logic              ack_new_day;
	} item_t;

	typedef struct packed {
		logic [FLAG_W-1:0] pending_flags;
		logic              new_day;
		logic [CNT_W-1:0]  tick_total;
		tod_t              tod;
		logic [CNT_W-1:0]  task_rate;
	} result_t;

endpackage

### src/tts_item_if.sv
`timescale 1ns / 1ps

interface tts_item_if;
	logic                      valid;
	logic                      ready;
	logic                      tick;
	logic                      task_ran;
	logic [tts_pkg::FLAG_W-1:0] ack_mask;
	logic                      ack_new_day;

	modport source (output valid, tick, task_ran, ack_mask, ack_new_day, input ready);
	modport sink (input valid, tick, task_ran, ack_mask, ack_new_day, output ready);
endinterface

### src/tts_result_if.sv
`timescale 1ns / 1ps

interface tts_result_if;
	logic                       valid;
	logic                       ready;
	logic [tts_pkg::FLAG_W-1:0] pending_flags;
	logic                       new_day;
	logic [tts_pkg::CNT_W-1:0]  tick_total;
	logic [tts_pkg::SEC_W-1:0]  clock_seconds;
	logic [tts_pkg::MIN_W-1:0]  clock_minutes;
	logic [tts_pkg::HR_W-1:0]   clock_hours;
	logic [tts_pkg::CNT_W-1:0]  task_rate;

	modport source (output valid, pending_flags, new_day, tick_total, clock_seconds,
		clock_minutes, clock_hours, task_rate, input ready);
	modport sink (input valid, pending_flags, new_day, tick_total, clock_seconds,
		clock_minutes, clock_hours, task_rate, output ready);
endinterface

### src/tts_cfg_if.sv
`timescale 1ns / 1ps

interface tts_cfg_if;
	logic                      valid;
	logic                      ready;
	logic [tts_pkg::IDX_W-1:0] index;
	logic [tts_pkg::DIV_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

### src/tick_task_scheduler_with_clock.sv
`timescale 1ns / 1ps
`include "tick_task_scheduler_with_clock_defines.svh"

// Tick-driven task scheduler with a time-of-day clock. One item is taken every clock cycle
// while the sink is ready, and each gives exactly one result: the item is registered,
// the divider counters, the seconds/minutes/hours clock and the flags are updated in one
// pass once the item advances and the result lands in an output register. The output register
// holds a result while the sink stalls and the item register keeps taking a new item
// whenever that result moves on, so throughput is one item per cycle with a ready sink.
// Registers are to be written through the config port only while the block is idle,
// which it does not enforce; the port is always ready, indexes past the list are ignored.
module tick_task_scheduler_with_clock (
	input logic           clk,
	input logic           arst_n,
	tts_item_if.sink      item,
	tts_result_if.source  result,
	tts_cfg_if.sink       cfg
);

	logic [tts_pkg::DIV_W-1:0] period_short_q;
	logic [tts_pkg::DIV_W-1:0] period_mid_q;
	logic [tts_pkg::DIV_W-1:0] period_long_q;
	logic [tts_pkg::DIV_W-1:0] ticks_per_sec_q;

	logic [tts_pkg::CNT_W-1:0]  tick_count_q;
	logic [tts_pkg::CNT_W-1:0]  run_count_q;
	logic [tts_pkg::CNT_W-1:0]  rate_q;
	logic [tts_pkg::FLAG_W-1:0] flags_q;
	logic                       day_q;

	tts_pkg::item_t   item_s1;
	logic             valid_s1;
	tts_pkg::result_t result_s2;
	logic             valid_s2;

	logic                       adv;
	logic                       div_en;
	logic                       hit_short;
	logic                       hit_mid;
	logic                       hit_long;
	logic                       hit_sec;
	logic                       wrap;
	tts_pkg::tod_t              tod_next;
	logic [tts_pkg::CNT_W-1:0]  run_inc;
	logic [tts_pkg::CNT_W-1:0]  tick_next;
	logic [tts_pkg::FLAG_W-1:0] flags_after;
	logic                       day_after;

	assign adv        = valid_s1 && (!valid_s2 || result.ready);
	assign item.ready = !valid_s1 || adv;
	assign cfg.ready  = 1'b1;
	assign div_en     = adv && item_s1.tick;

	tts_divider u_div_short (.clk, .arst_n, .en(div_en), .period(period_short_q), .hit(hit_short));
	tts_divider u_div_mid   (.clk, .arst_n, .en(div_en), .period(period_mid_q), .hit(hit_mid));
	tts_divider u_div_long  (.clk, .arst_n, .en(div_en), .period(period_long_q), .hit(hit_long));
	tts_divider u_div_sec   (.clk, .arst_n, .en(div_en), .period(ticks_per_sec_q), .hit(hit_sec));

	tts_clock u_clock (.clk, .arst_n, .advance(hit_sec), .tod_next, .wrap);

	// run event counts before the tick, so a second boundary captures it
	assign run_inc     = run_count_q + {{(tts_pkg::CNT_W-1){1'b0}}, item_s1.task_ran};
	assign tick_next   = tick_count_q + {{(tts_pkg::CNT_W-1){1'b0}}, item_s1.tick};
	assign flags_after = flags_q | {hit_long, hit_mid, hit_short, item_s1.tick};
	assign day_after   = day_q || wrap;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_short_q  <= tts_pkg::PERIOD_SHORT_RST;
			period_mid_q    <= tts_pkg::PERIOD_MID_RST;
			period_long_q   <= tts_pkg::PERIOD_LONG_RST;
			ticks_per_sec_q <= tts_pkg::TICKS_PER_SEC_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				tts_pkg::REG_PERIOD_SHORT:  period_short_q  <= cfg.data;
				tts_pkg::REG_PERIOD_MID:    period_mid_q    <= cfg.data;
				tts_pkg::REG_PERIOD_LONG:   period_long_q   <= cfg.data;
				tts_pkg::REG_TICKS_PER_SEC: ticks_per_sec_q <= cfg.data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.ready && item.valid) begin
			item_s1 <= '{tick: item.tick, task_ran: item.task_ran,
				ack_mask: item.ack_mask, ack_new_day: item.ack_new_day};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_count_q <= '0;
			run_count_q  <= '0;
			rate_q       <= '0;
			flags_q      <= '0;
			day_q        <= 1'b0;
			valid_s2     <= 1'b0;
		end else if (adv) begin
			tick_count_q <= tick_next;
			run_count_q  <= hit_sec ? '0 : run_inc;
			if (hit_sec) begin
				rate_q <= run_inc;
			end
			flags_q  <= flags_after & ~item_s1.ack_mask;
			day_q    <= day_after && !item_s1.ack_new_day;
			valid_s2 <= 1'b1;
		end else if (result.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			result_s2.pending_flags <= flags_after;
			result_s2.new_day       <= day_after;
			result_s2.tick_total    <= tick_next;
			result_s2.tod           <= tod_next;
			result_s2.task_rate     <= hit_sec ? run_inc : rate_q;
		end
	end

	assign result.valid         = valid_s2;
	assign result.pending_flags = result_s2.pending_flags;
	assign result.new_day       = result_s2.new_day;
	assign result.tick_total    = result_s2.tick_total;
	assign result.clock_seconds = result_s2.tod.sec;
	assign result.clock_minutes = result_s2.tod.min;
	assign result.clock_hours   = result_s2.tod.hr;
	assign result.task_rate     = result_s2.task_rate;

	`TTS_ASSERT_IMP(a_stall_blocks, clk, arst_n, valid_s2 && !result.ready, !adv)
	`TTS_ASSERT_NXT(a_tick_base_flag, clk, arst_n, div_en, valid_s2 && result_s2.pending_flags[0])
	`TTS_ASSERT_NXT(a_second_clears_run, clk, arst_n, hit_sec, run_count_q == '0)

endmodule

### src/tts_divider.sv
`timescale 1ns / 1ps
`include "tick_task_scheduler_with_clock_defines.svh"

module tts_divider (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic [tts_pkg::DIV_W-1:0] period,
	output logic                      hit
);

	logic [tts_pkg::DIV_W-1:0] count_q;
	logic [tts_pkg::DIV_W:0]   count_inc;

	// one extra bit: a count left above a lowered period still reaches it
	assign count_inc = {1'b0, count_q} + {{tts_pkg::DIV_W{1'b0}}, 1'b1};
	assign hit = en && (count_inc >= {1'b0, period});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (en) begin
			if (hit) begin
				count_q <= '0;
			end else begin
				count_q <= count_inc[tts_pkg::DIV_W-1:0];
			end
		end
	end

	`TTS_ASSERT_NXT(a_hit_restarts, clk, arst_n, hit, count_q == '0)
	`TTS_ASSERT_NXT(a_idle_holds, clk, arst_n, !en, $stable(count_q))

endmodule

### src/tts_clock.sv
`timescale 1ns / 1ps
`include "tick_task_scheduler_with_clock_defines.svh"

module tts_clock (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          advance,
	output tts_pkg::tod_t tod_next,
	output logic          wrap
);

	tts_pkg::tod_t           tod_q;
	logic [tts_pkg::SEC_W:0] sec_inc;
	logic [tts_pkg::MIN_W:0] min_inc;
	logic [tts_pkg::HR_W:0]  hr_inc;
	logic                    sec_wrap;
	logic                    min_wrap;
	logic                    hr_wrap;

	assign sec_inc  = {1'b0, tod_q.sec} + {{tts_pkg::SEC_W{1'b0}}, 1'b1};
	assign min_inc  = {1'b0, tod_q.min} + {{tts_pkg::MIN_W{1'b0}}, 1'b1};
	assign hr_inc   = {1'b0, tod_q.hr} + {{tts_pkg::HR_W{1'b0}}, 1'b1};
	assign sec_wrap = sec_inc >= tts_pkg::SEC_MOD;
	assign min_wrap = min_inc >= tts_pkg::MIN_MOD;
	assign hr_wrap  = hr_inc >= tts_pkg::HR_MOD;
	assign wrap     = advance && sec_wrap && min_wrap && hr_wrap;

	always_comb begin
		tod_next = tod_q;
		if (advance) begin
			if (!sec_wrap) begin
				tod_next.sec = sec_inc[tts_pkg::SEC_W-1:0];
			end else begin
				tod_next.sec = '0;
				if (!min_wrap) begin
					tod_next.min = min_inc[tts_pkg::MIN_W-1:0];
				end else begin
					tod_next.min = '0;
					tod_next.hr = hr_wrap ? '0 : hr_inc[tts_pkg::HR_W-1:0];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tod_q <= '0;
		end else begin
			tod_q <= tod_next;
		end
	end

	`TTS_ASSERT_IMP(a_sec_range, clk, arst_n, 1'b1, {1'b0, tod_q.sec} < tts_pkg::SEC_MOD)
	`TTS_ASSERT_IMP(a_min_range, clk, arst_n, 1'b1, {1'b0, tod_q.min} < tts_pkg::MIN_MOD)
	`TTS_ASSERT_NXT(a_midnight, clk, arst_n, wrap, tod_q == '0)

endmodule

### bench/testbench.sv
`timescale 1ns / 1ps

module testbench;

	localparam int CYCLE_LIMIT = 600000;
	localparam int RANDOM_PHASES = 12;
	localparam int LAST_ITEMS = 120;
	localparam int HOLD_CYCLES = 48;

	// divider slots, same order as the period registers
	localparam int DIV_SHORT  = 0;
	localparam int DIV_MID    = 1;
	localparam int DIV_LONG   = 2;
	localparam int DIV_SECOND = 3;

	typedef logic [tts_pkg::FLAG_W-1:0] flags_t;
	typedef logic [tts_pkg::IDX_W-1:0]  idx_t;
	typedef logic [tts_pkg::DIV_W-1:0]  val_t;
	typedef logic [tts_pkg::CNT_W-1:0]  cnt_t;

	localparam flags_t FLAG_BASE  = 4'b0001;
	localparam flags_t FLAG_SHORT = 4'b0010;
	localparam flags_t FLAG_MID   = 4'b0100;
	localparam flags_t FLAG_LONG  = 4'b1000;
	localparam flags_t ACK_NONE   = 4'b0000;
	localparam flags_t ACK_ALL    = 4'b1111;

	localparam idx_t REG_UNMAPPED_FIRST = tts_pkg::REG_TICKS_PER_SEC + 8'd1;
	localparam idx_t REG_UNMAPPED_LAST  = 8'hFF;

	typedef struct {
		bit                is_write;
		idx_t              reg_idx;
		val_t              reg_val;
		tts_pkg::item_t    stim;
		bit                typed;
		tts_pkg::result_t  want;
	} plan_row_t;

	logic clk;
	logic arst_n;

	tts_item_if   item_ch();
	tts_result_if res_ch();
	tts_cfg_if    cfg_ch();

	tick_task_scheduler_with_clock i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (res_ch),
		.cfg    (cfg_ch)
	);

	// scheduler mirror
	val_t                        period_cfg [4];
	val_t                        div_cnt [4];
	cnt_t                        ticks_seen;
	flags_t                      flags_q;
	logic                        midnight_seen;
	logic [tts_pkg::SEC_W-1:0]   tod_sec;
	logic [tts_pkg::MIN_W-1:0]   tod_min;
	logic [tts_pkg::HR_W-1:0]    tod_hr;
	cnt_t                        runs_in_second;
	cnt_t                        runs_last_second;

	tts_pkg::result_t pending_results[$];
	plan_row_t        directed_rows[$];

	int  mismatches = 0;
	int  items_sent = 0;
	int  writes_done = 0;
	int  results_checked = 0;
	int  new_day_results = 0;
	int  cycle_count = 0;
	bit  tx_idle_on = 1'b1;
	bit  rx_idle_on = 1'b1;
	bit  rx_hold_req = 1'b0;

	function automatic bit divider_fires(int k);
		logic [tts_pkg::DIV_W:0] nxt;
		nxt = {1'b0, div_cnt[k]} + 1'b1;
		if (nxt >= {1'b0, period_cfg[k]}) begin
			div_cnt[k] = '0;
			return 1'b1;
		end
		div_cnt[k] = nxt[tts_pkg::DIV_W-1:0];
		return 1'b0;
	endfunction

	function automatic tts_pkg::result_t schedule_step(tts_pkg::item_t it);
		tts_pkg::result_t r;
		if (it.task_ran)
			runs_in_second = runs_in_second + 1'b1;
		if (it.tick) begin
			ticks_seen = ticks_seen + 1'b1;
			flags_q = flags_q | FLAG_BASE;
			if (divider_fires(DIV_SHORT))
				flags_q = flags_q | FLAG_SHORT;
			if (divider_fires(DIV_MID))
				flags_q = flags_q | FLAG_MID;
			if (divider_fires(DIV_LONG))
				flags_q = flags_q | FLAG_LONG;
			if (divider_fires(DIV_SECOND)) begin
				runs_last_second = runs_in_second;
				runs_in_second = '0;
				tod_sec = tod_sec + 1'b1;
				if ({1'b0, tod_sec} >= tts_pkg::SEC_MOD) begin
					tod_sec = '0;
					tod_min = tod_min + 1'b1;
					if ({1'b0, tod_min} >= tts_pkg::MIN_MOD) begin
						tod_min = '0;
						tod_hr = tod_hr + 1'b1;
						if ({1'b0, tod_hr} >= tts_pkg::HR_MOD) begin
							tod_hr = '0;
							midnight_seen = 1'b1;
						end
					end
				end
			end
		end
		r.pending_flags = flags_q;
		r.new_day = midnight_seen;
		r.tick_total = ticks_seen;
		r.tod.sec = tod_sec;
		r.tod.min = tod_min;
		r.tod.hr = tod_hr;
		r.task_rate = runs_last_second;
		// reported first, then read-and-clear
		flags_q = flags_q & ~it.ack_mask;
		if (it.ack_new_day)
			midnight_seen = 1'b0;
		return r;
	endfunction

	function automatic plan_row_t stim_row(logic tk, logic ran, flags_t ack, logic ackd);
		plan_row_t row;
		row.is_write = 1'b0;
		row.reg_idx = '0;
		row.reg_val = '0;
		row.stim.tick = tk;
		row.stim.task_ran = ran;
		row.stim.ack_mask = ack;
		row.stim.ack_new_day = ackd;
		row.typed = 1'b0;
		row.want = '0;
		return row;
	endfunction

	function automatic void plan_item(logic tk, logic ran, flags_t ack, logic ackd);
		directed_rows.push_back(stim_row(tk, ran, ack, ackd));
	endfunction

	// rows near reset: clock at midnight, no rate captured yet
	function automatic void plan_known(logic tk, logic ran, flags_t ack, logic ackd,
			flags_t flags, cnt_t total);
		plan_row_t row;
		row = stim_row(tk, ran, ack, ackd);
		row.typed = 1'b1;
		row.want.pending_flags = flags;
		row.want.tick_total = total;
		directed_rows.push_back(row);
	endfunction

	function automatic void plan_write(idx_t idx, val_t val);
		plan_row_t row;
		row = stim_row(1'b0, 1'b0, ACK_NONE, 1'b0);
		row.is_write = 1'b1;
		row.reg_idx = idx;
		row.reg_val = val;
		directed_rows.push_back(row);
	endfunction

	function automatic tts_pkg::item_t rand_item(int tick_pct, int day_ack_pct);
		tts_pkg::item_t it;
		it.tick = ($urandom_range(0, 99) < tick_pct);
		it.task_ran = 1'($urandom_range(0, 1));
		it.ack_mask = flags_t'($urandom_range(0, 15));
		it.ack_new_day = ($urandom_range(0, 99) < day_ack_pct);
		return it;
	endfunction

	function automatic val_t pick_period();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2: return 16'd1;
			3: return val_t'($urandom_range(0, 65535));
			default: return val_t'($urandom_range(1, 12));
		endcase
	endfunction

	function automatic void check_field(string name, cnt_t want, cnt_t got);
		if (want !== got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			mismatches++;
		end
	endfunction

	// enters and leaves at a falling edge; valid stays up for back-to-back transfers
	task automatic send_item(tts_pkg::item_t it, bit typed, tts_pkg::result_t want);
		if (tx_idle_on && $urandom_range(0, 4) == 0) begin
			item_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(negedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.tick <= it.tick;
		item_ch.task_ran <= it.task_ran;
		item_ch.ack_mask <= it.ack_mask;
		item_ch.ack_new_day <= it.ack_new_day;
		do @(posedge clk); while (!item_ch.ready);
		want = typed ? want : schedule_step(it);
		if (typed)
			void'(schedule_step(it));
		pending_results.push_back(want);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic write_reg(idx_t idx, val_t val);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= val;
		do @(posedge clk); while (!cfg_ch.ready);
		if (idx <= tts_pkg::REG_TICKS_PER_SEC)
			period_cfg[idx[1:0]] = val;
		writes_done++;
		@(negedge clk);
	endtask

	task automatic wait_drained();
		do @(negedge clk); while (pending_results.size() != 0);
	endtask

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d results outstanding", cycle_count,
				pending_results.size());
			$display("Regression FAIL");
			$finish;
		end
	end

	// result receiver: short random stalls, plus one long hold-off when asked
	initial begin
		int stall;
		stall = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (rx_hold_req) begin
				rx_hold_req = 1'b0;
				stall = HOLD_CYCLES;
			end
			if (stall > 0) begin
				res_ch.ready <= 1'b0;
				stall--;
			end else begin
				res_ch.ready <= 1'b1;
				if (rx_idle_on && $urandom_range(0, 5) == 0)
					stall = $urandom_range(1, 3);
			end
		end
	end

	always @(posedge clk) begin
		tts_pkg::result_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (pending_results.size() == 0) begin
				$error("result transfer with nothing outstanding");
				mismatches++;
			end else begin
				want = pending_results.pop_front();
				check_field("pending_flags", cnt_t'(want.pending_flags),
					cnt_t'(res_ch.pending_flags));
				check_field("new_day", cnt_t'(want.new_day), cnt_t'(res_ch.new_day));
				check_field("tick_total", want.tick_total, res_ch.tick_total);
				check_field("clock_seconds", cnt_t'(want.tod.sec),
					cnt_t'(res_ch.clock_seconds));
				check_field("clock_minutes", cnt_t'(want.tod.min),
					cnt_t'(res_ch.clock_minutes));
				check_field("clock_hours", cnt_t'(want.tod.hr), cnt_t'(res_ch.clock_hours));
				check_field("task_rate", want.task_rate, res_ch.task_rate);
				results_checked++;
				if (res_ch.new_day)
					new_day_results++;
			end
		end
	end

	initial begin
		tts_pkg::result_t none;
		int               n;

		arst_n = 1'b0;
		item_ch.valid = 1'b0;
		item_ch.tick = 1'b0;
		item_ch.task_ran = 1'b0;
		item_ch.ack_mask = '0;
		item_ch.ack_new_day = 1'b0;
		res_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = '0;
		cfg_ch.data = '0;
		none = '0;

		period_cfg[DIV_SHORT] = tts_pkg::PERIOD_SHORT_RST;
		period_cfg[DIV_MID] = tts_pkg::PERIOD_MID_RST;
		period_cfg[DIV_LONG] = tts_pkg::PERIOD_LONG_RST;
		period_cfg[DIV_SECOND] = tts_pkg::TICKS_PER_SEC_RST;
		foreach (div_cnt[k])
			div_cnt[k] = '0;
		ticks_seen = '0;
		flags_q = '0;
		midnight_seen = 1'b0;
		tod_sec = '0;
		tod_min = '0;
		tod_hr = '0;
		runs_in_second = '0;
		runs_last_second = '0;

		// reset periods: short divider fires on the fifth tick
		plan_known(1'b0, 1'b0, ACK_NONE, 1'b0, ACK_NONE, 32'd0);
		plan_known(1'b1, 1'b0, ACK_NONE, 1'b0, FLAG_BASE, 32'd1);
		plan_known(1'b1, 1'b0, ACK_ALL, 1'b0, FLAG_BASE, 32'd2);
		plan_known(1'b0, 1'b0, ACK_NONE, 1'b0, ACK_NONE, 32'd2);
		plan_known(1'b0, 1'b1, ACK_NONE, 1'b0, ACK_NONE, 32'd2);
		plan_known(1'b1, 1'b0, ACK_NONE, 1'b0, FLAG_BASE, 32'd3);
		plan_known(1'b1, 1'b1, ACK_NONE, 1'b0, FLAG_BASE, 32'd4);
		plan_known(1'b1, 1'b0, FLAG_BASE, 1'b0, FLAG_BASE | FLAG_SHORT, 32'd5);
		plan_known(1'b0, 1'b0, FLAG_SHORT, 1'b1, FLAG_SHORT, 32'd5);
		// zero period, one, the top, a one-tick second; unmapped indexes do nothing
		plan_write(tts_pkg::REG_PERIOD_SHORT, 16'd0);
		plan_write(tts_pkg::REG_PERIOD_MID, 16'd1);
		plan_write(tts_pkg::REG_PERIOD_LONG, 16'hFFFF);
		plan_write(tts_pkg::REG_TICKS_PER_SEC, 16'd1);
		plan_write(REG_UNMAPPED_FIRST, 16'hFFFF);
		plan_write(REG_UNMAPPED_LAST, 16'h0007);
		plan_item(1'b1, 1'b1, 4'b0101, 1'b0);
		plan_item(1'b1, 1'b0, 4'b1010, 1'b1);
		plan_item(1'b0, 1'b1, ACK_ALL, 1'b1);
		plan_item(1'b1, 1'b1, ACK_NONE, 1'b0);
		plan_item(1'b1, 1'b1, ACK_ALL, 1'b1);
		// long period drops under the running count: fires on the next tick
		plan_write(tts_pkg::REG_PERIOD_LONG, 16'd1);
		plan_write(tts_pkg::REG_TICKS_PER_SEC, 16'hFFFF);
		plan_write(tts_pkg::REG_PERIOD_SHORT, 16'hFFFF);
		plan_write(tts_pkg::REG_PERIOD_MID, 16'd2);
		plan_item(1'b1, 1'b0, ACK_NONE, 1'b0);
		plan_item(1'b1, 1'b1, FLAG_LONG, 1'b0);
		plan_item(1'b0, 1'b0, ACK_ALL, 1'b0);
		plan_item(1'b1, 1'b1, ACK_ALL, 1'b1);

		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].is_write) begin
				if (i > 0 && !directed_rows[i-1].is_write) begin
					item_ch.valid <= 1'b0;
					wait_drained();
				end
				write_reg(directed_rows[i].reg_idx, directed_rows[i].reg_val);
			end else begin
				if (i > 0 && directed_rows[i-1].is_write)
					cfg_ch.valid <= 1'b0;
				send_item(directed_rows[i].stim, directed_rows[i].typed, directed_rows[i].want);
			end
		end
		item_ch.valid <= 1'b0;

		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			wait_drained();
			for (int r = tts_pkg::REG_PERIOD_SHORT; r <= tts_pkg::REG_TICKS_PER_SEC; r++)
				if ($urandom_range(0, 9) < 6)
					write_reg(idx_t'(r), pick_period());
			if ($urandom_range(0, 3) == 0)
				write_reg(idx_t'($urandom_range(REG_UNMAPPED_FIRST, REG_UNMAPPED_LAST)),
					val_t'($urandom()));
			cfg_ch.valid <= 1'b0;
			tx_idle_on = ($urandom_range(0, 3) != 0);
			rx_idle_on = ($urandom_range(0, 3) != 0);
			// block fills while results are held back
			if (ph == 3 || ph == 9)
				rx_hold_req = 1'b1;
			n = $urandom_range(60, 100);
			for (int k = 0; k < n; k++) begin
				if (k == n / 2 && $urandom_range(0, 2) == 0) begin
					item_ch.valid <= 1'b0;
					wait_drained();
				end
				send_item(rand_item(75, 20), 1'b0, none);
			end
			item_ch.valid <= 1'b0;
		end

		// one-tick seconds at full rate, no idling on either side
		wait_drained();
		write_reg(tts_pkg::REG_TICKS_PER_SEC, 16'd1);
		write_reg(tts_pkg::REG_PERIOD_SHORT, pick_period());
		write_reg(tts_pkg::REG_PERIOD_MID, pick_period());
		write_reg(tts_pkg::REG_PERIOD_LONG, pick_period());
		cfg_ch.valid <= 1'b0;
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b0;
		for (int k = 0; k < LAST_ITEMS; k++)
			send_item(rand_item(95, 6), 1'b0, none);
		item_ch.valid <= 1'b0;

		wait_drained();
		repeat (8) @(posedge clk);
		if (pending_results.size() != 0) begin
			$error("%0d results never arrived", pending_results.size());
			mismatches++;
		end
		$display("Sent %0d items and %0d register writes; checked %0d results", items_sent,
			writes_done, results_checked);
		$display("Periods from zero to the top, stalls and fast seconds: %0d new-day results, %0d mismatches",
			new_day_results, mismatches);
		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

### sim.f
+incdir+src
src/tts_pkg.sv
src/tts_item_if.sv
src/tts_result_if.sv
src/tts_cfg_if.sv
src/tts_divider.sv
src/tts_clock.sv
src/tick_task_scheduler_with_clock.sv
bench/testbench.sv
